### sv/cti_pkg.sv
`timescale 1ns / 1ps
package cti_pkg;
	localparam int MatrixEntries = 9;
	localparam int TableDepth = 3 * MatrixEntries;
	localparam logic [27:0] MiredQ8Num = 28'd256000000;
	localparam logic [16:0] OneQ16 = 17'h10000;

	typedef struct packed {
		logic load;
		logic start_div;
		logic [1:0] div_sel;
		logic start_wdiv;
		logic blend;
		logic fix;
		logic emit_raw;
		logic emit_mix;
		logic [1:0] raw_sel;
		logic hi_pair;
		logic [3:0] entry;
		logic [1:0] row;
	} cti_cmd_t;

	typedef struct packed {
		logic div_done;
		logic calib_bad;
		logic above;
		logic below;
		logic upper_half;
	} cti_stat_t;

	function automatic logic signed [16:0] sm_decode(input logic [15:0] v);
		logic signed [16:0] mag;
		mag = {2'b00, v[14:0]};
		return v[15] ? -mag : mag;
	endfunction

	function automatic logic [15:0] sm_encode(input logic signed [17:0] v);
		logic signed [17:0] c;
		logic [17:0] n;
		c = v;
		if (c > 18'sd32767) c = 18'sd32767;
		else if (c < -18'sd32767) c = -18'sd32767;
		n = -c;
		return (c < 0) ? {1'b1, n[14:0]} : {1'b0, c[14:0]};
	endfunction
endpackage

### sv/cti_datapath.sv
`timescale 1ns / 1ps
module cti_datapath (
	input logic clk,
	input logic arst_n,
	input cti_pkg::cti_cmd_t cmd,
	output cti_pkg::cti_stat_t stat,
	input logic [4:0] coef_index,
	input logic [15:0] coef_value,
	input logic [15:0] color_temp,
	input logic [15:0] high_t,
	input logic [15:0] mid_t,
	input logic [15:0] low_t,
	output logic [15:0] res_q [cti_pkg::MatrixEntries]
);
	import cti_pkg::*;

	logic [15:0] tbl_q [TableDepth];
	logic [27:0] m_q, ma_q, mb_q;
	logic [16:0] w_q;
	logic signed [17:0] bl_q [MatrixEntries];

	// shared restoring divider, one quotient bit a cycle
	logic [44:0] num_q;
	logic [43:0] den_q;
	logic [44:0] rem_q;
	logic [44:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [1:0] dst_q;
	logic [45:0] trial;
	logic [44:0] dnum;
	logic [43:0] dden;
	logic [27:0] pos, span;

	assign pos = m_q - ma_q;
	assign span = mb_q - ma_q;
	assign trial = {rem_q, num_q[44]} - {2'b00, den_q};

	// scene mired is started in the accept cycle, so the live input is the divisor
	always_comb begin
		dnum = {17'd0, MiredQ8Num};
		dden = {28'd0, color_temp};
		unique case (cmd.div_sel)
			2'd0: dden = {28'd0, color_temp};
			2'd1: dden = {28'd0, cmd.hi_pair ? high_t : mid_t};
			2'd2: dden = {28'd0, cmd.hi_pair ? mid_t : low_t};
			default: begin
				dnum = {1'b0, pos, 16'd0} + {18'd0, span[27:1]};
				dden = {16'd0, span};
			end
		endcase
	end

	// tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TableDepth; i++) tbl_q[i] <= '0;
		end else if (cmd.load && coef_index < 5'(TableDepth)) begin
			tbl_q[coef_index] <= coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start_div || cmd.start_wdiv) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd45;
			num_q <= dnum;
			den_q <= dden;
			rem_q <= '0;
			quo_q <= '0;
			dst_q <= cmd.div_sel;
		end else if (busy_q) begin
			if (!trial[45]) begin
				rem_q <= trial[44:0];
				quo_q <= {quo_q[43:0], 1'b1};
			end else begin
				rem_q <= {rem_q[43:0], num_q[44]};
				quo_q <= {quo_q[43:0], 1'b0};
			end
			num_q <= {num_q[43:0], 1'b0};
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	logic fin;
	logic [44:0] qf;
	assign fin = busy_q && cnt_q == 6'd1;
	assign qf = {quo_q[43:0], ~trial[45]};
	assign stat.div_done = fin;

	logic [16:0] wsel;
	always_comb begin
		if (m_q <= ma_q) wsel = '0;
		else if (m_q >= mb_q) wsel = OneQ16;
		else wsel = qf[16:0];
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			unique case (dst_q)
				2'd0: m_q <= qf[27:0];
				2'd1: ma_q <= qf[27:0];
				2'd2: mb_q <= qf[27:0];
				default: w_q <= wsel;
			endcase
		end
	end

	// blend one entry per cycle
	logic [4:0] ia, ib;
	logic signed [34:0] v;
	logic [34:0] av;
	logic [18:0] qv;
	assign ia = cmd.hi_pair ? 5'(cmd.entry) : 5'(cmd.entry) + 5'(MatrixEntries);
	assign ib = ia + 5'(MatrixEntries);
	assign v = sm_decode(tbl_q[ia]) * $signed({1'b0, OneQ16 - w_q})
		+ sm_decode(tbl_q[ib]) * $signed({1'b0, w_q});
	assign av = v[34] ? 35'(-v) : 35'(v);
	assign qv = 19'((av + 35'h8000) >> 16);

	logic [1:0] r;
	logic [3:0] rb, dg;
	logic signed [17:0] sum;
	assign r = cmd.row;
	assign rb = 4'(r) * 4'd3;
	assign dg = rb + 4'(r);
	assign sum = bl_q[rb] + bl_q[rb + 4'd1] + bl_q[rb + 4'd2];

	logic [4:0] rbase;
	assign rbase = (cmd.raw_sel == 2'd0) ? 5'd0 :
		(cmd.raw_sel == 2'd1) ? 5'(MatrixEntries) : 5'(2 * MatrixEntries);

	always_ff @(posedge clk) begin
		if (cmd.blend) bl_q[cmd.entry] <= v[34] ? -$signed({1'b0, qv[16:0]}) :
			$signed({1'b0, qv[16:0]});
		if (cmd.fix) bl_q[dg] <= bl_q[dg] + 18'sd256 - sum;
		for (int i = 0; i < MatrixEntries; i++) begin
			if (cmd.emit_raw) res_q[i] <= tbl_q[rbase + 5'(i)];
			if (cmd.emit_mix) res_q[i] <= sm_encode(bl_q[i]);
		end
	end

	assign stat.calib_bad = color_temp == 0 || high_t == 0 || mid_t == 0 || low_t == 0
		|| high_t <= mid_t || mid_t <= low_t;
	assign stat.above = color_temp >= high_t;
	assign stat.below = color_temp <= low_t;
	assign stat.upper_half = color_temp >= mid_t;
endmodule

### sv/cti_ctrl.sv
`timescale 1ns / 1ps
module cti_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	output logic out_valid,
	input logic out_ready,
	input cti_pkg::cti_stat_t stat,
	output cti_pkg::cti_cmd_t cmd
);
	import cti_pkg::*;

	typedef enum logic [2:0] {IDLE, DIV, WDIV, BLEND, FIX, EMIT, HOLD} state_t;
	state_t state_q;
	logic [1:0] step_q;
	logic hi_q;
	logic [3:0] ent_q;
	logic [1:0] row_q;
	logic take;

	assign in_ready = state_q == IDLE && !out_valid;
	assign take = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.hi_pair = hi_q;
		cmd.entry = ent_q;
		cmd.row = row_q;
		cmd.load = take && !kind;
		if (take && kind) begin
			if (stat.calib_bad) begin cmd.emit_raw = 1'b1; cmd.raw_sel = 2'd1; end
			else if (stat.above) begin cmd.emit_raw = 1'b1; cmd.raw_sel = 2'd0; end
			else if (stat.below) begin cmd.emit_raw = 1'b1; cmd.raw_sel = 2'd2; end
			else begin cmd.start_div = 1'b1; cmd.div_sel = 2'd0; end
		end
		if (state_q == DIV && stat.div_done) begin
			if (step_q != 2'd2) begin
				cmd.start_div = 1'b1;
				cmd.div_sel = step_q + 2'd1;
			end
		end
		if (state_q == WDIV && step_q == 2'd0) begin
			cmd.start_wdiv = 1'b1;
			cmd.div_sel = 2'd3;
		end
		cmd.blend = state_q == BLEND;
		cmd.fix = state_q == FIX;
		cmd.emit_mix = state_q == EMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
			step_q <= '0;
			hi_q <= 1'b0;
			ent_q <= '0;
			row_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: if (take && kind) begin
					if (cmd.emit_raw) out_valid <= 1'b1;
					else begin
						state_q <= DIV;
						step_q <= '0;
						hi_q <= stat.upper_half;
					end
				end
				DIV: if (stat.div_done) begin
					if (step_q == 2'd2) begin state_q <= WDIV; step_q <= '0; end
					else step_q <= step_q + 2'd1;
				end
				WDIV: begin
					step_q <= 2'd1;
					if (stat.div_done) begin state_q <= BLEND; ent_q <= '0; end
				end
				BLEND: begin
					ent_q <= ent_q + 4'd1;
					if (ent_q == 4'(MatrixEntries - 1)) begin state_q <= FIX; row_q <= '0; end
				end
				FIX: begin
					row_q <= row_q + 2'd1;
					if (row_q == 2'd2) state_q <= EMIT;
				end
				EMIT: begin out_valid <= 1'b1; state_q <= IDLE; end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### sv/ccm_temperature_interpolator.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// in        in_valid / in_ready     kind, coef_index, coef_value, color_temp
// out       out_valid / out_ready   coef_r0_c0 .. coef_r2_c2
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
// Loads and raw returns use no divider pass. A blended item runs four passes of the
// shared divider (three mireds, then the weight), nine entry blends, three row
// fixes and one output step before the result is shown.
// Reset clears the coefficient table and the three temperature registers.
// Input is held off while a result waits on the output.
module ccm_temperature_interpolator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [4:0] coef_index,
	input logic [15:0] coef_value,
	input logic [15:0] color_temp,
	output logic out_valid,
	input logic out_ready,
	output logic [15:0] coef_r0_c0,
	output logic [15:0] coef_r0_c1,
	output logic [15:0] coef_r0_c2,
	output logic [15:0] coef_r1_c0,
	output logic [15:0] coef_r1_c1,
	output logic [15:0] coef_r1_c2,
	output logic [15:0] coef_r2_c0,
	output logic [15:0] coef_r2_c1,
	output logic [15:0] coef_r2_c2,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	import cti_pkg::*;

	logic [15:0] high_q, mid_q, low_q;
	cti_cmd_t cmd;
	cti_stat_t stat;
	logic [15:0] res [MatrixEntries];

	assign cfg_ready = 1'b1;

	// temperature registers; index 3 is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= '0;
			mid_q <= '0;
			low_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				2'd0: high_q <= cfg_data;
				2'd1: mid_q <= cfg_data;
				2'd2: low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cti_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .kind,
		.out_valid, .out_ready, .stat, .cmd
	);

	cti_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .coef_index, .coef_value, .color_temp,
		.high_t(high_q), .mid_t(mid_q), .low_t(low_q), .res_q(res)
	);

	assign coef_r0_c0 = res[0];
	assign coef_r0_c1 = res[1];
	assign coef_r0_c2 = res[2];
	assign coef_r1_c0 = res[3];
	assign coef_r1_c1 = res[4];
	assign coef_r1_c2 = res[5];
	assign coef_r2_c0 = res[6];
	assign coef_r2_c1 = res[7];
	assign coef_r2_c2 = res[8];
endmodule
